// ===== src/tdm_pkg.sv =====
// Shared types and constants for the tension damage material step block.
// Used by tdm_alu and tension_damage_material_step; no dependencies.
package tdm_pkg;

    localparam int unsigned ExpTerms  = 20;
    localparam int unsigned ExpCutoff = 44;

    localparam logic [31:0] ModReset      = 32'd1966080000;
    localparam logic [31:0] StrengthReset = 32'd196608;
    localparam logic [31:0] FracReset     = 32'd655;
    localparam logic [30:0] PeakReset     = 31'd6872;

    localparam logic [31:0] OneQ31 = 32'h8000_0000;
    localparam logic [63:0] OneQ62 = 64'h4000_0000_0000_0000;
    localparam logic [63:0] XLimit = {26'd0, 6'(ExpCutoff), 32'd0};

    // configuration register indexes
    localparam logic [7:0] CFG_MODULUS  = 8'd0;
    localparam logic [7:0] CFG_STRENGTH = 8'd1;
    localparam logic [7:0] CFG_FRACTURE = 8'd2;
    localparam logic [7:0] CFG_PEAK     = 8'd3;

    // operation codes
    localparam logic [1:0] FUNC_SET    = 2'd0;
    localparam logic [1:0] FUNC_COMMIT = 2'd1;
    localparam logic [1:0] FUNC_REVERT = 2'd2;
    localparam logic [1:0] FUNC_START  = 2'd3;

    typedef enum logic {
        ALU_MUL = 1'b0,
        ALU_DIV = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_rsp_t;

endpackage

// ===== src/tdm_alu.sv =====
// Shared arithmetic unit: 64x64 multiply over four 32x32 partial products,
// or 128/64 restoring division one quotient bit per cycle. Uses tdm_pkg.
module tdm_alu (
    input  logic               aclk,
    input  logic               aresetn,
    input  tdm_pkg::alu_req_t  req,
    input  logic [63:0]        opa,     // multiplicand, or dividend high word
    input  logic [63:0]        opb,     // multiplier, or dividend low word
    input  logic [63:0]        opc,     // divisor
    output tdm_pkg::alu_rsp_t  rsp,
    output logic [127:0]       res      // product, or quotient in low word
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    tdm_pkg::alu_op_t  op_reg, op_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [63:0]       a_reg, a_next;
    logic [63:0]       b_reg, b_next;
    logic [63:0]       d_reg, d_next;
    logic [127:0]      acc_reg, acc_next;
    logic [63:0]       prod_reg, prod_next;
    logic              pv_reg, pv_next;
    logic [1:0]        sh_reg, sh_next;

    logic [31:0]  a_part, b_part;
    logic [63:0]  prod;
    logic [127:0] addend;
    logic [63:0]  rem_shift;
    logic         qbit;

    // partial product selection
    assign a_part = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_part = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
    assign prod   = {32'd0, a_part} * {32'd0, b_part};

    always_comb begin
        unique case (sh_reg)
            2'd0:    addend = {64'd0, prod_reg};
            2'd1:    addend = {32'd0, prod_reg, 32'd0};
            2'd2:    addend = {prod_reg, 64'd0};
            default: addend = '0;
        endcase
    end

    // one restoring step
    assign rem_shift = {a_reg[62:0], b_reg[63]};
    assign qbit      = a_reg[63] || (rem_shift >= d_reg);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        d_next    = d_reg;
        acc_next  = acc_reg;
        prod_next = prod_reg;
        pv_next   = pv_reg;
        sh_next   = sh_reg;
        if (req.start) begin
            op_next   = req.op;
            a_next    = opa;
            b_next    = opb;
            d_next    = opc;
            cnt_next  = '0;
            acc_next  = '0;
            pv_next   = 1'b0;
            busy_next = 1'b1;
            // quotient would not fit: all ones
            if (req.op == tdm_pkg::ALU_DIV && (opc == 64'd0 || opa >= opc)) begin
                acc_next  = {64'd0, {64{1'b1}}};
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (busy_reg) begin
            unique case (op_reg)
                tdm_pkg::ALU_MUL: begin
                    if (cnt_reg < 6'd4) begin
                        prod_next = prod;
                        sh_next   = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
                        pv_next   = 1'b1;
                    end
                    if (pv_reg) begin
                        acc_next = acc_reg + addend;
                    end
                    cnt_next = cnt_reg + 6'd1;
                    if (cnt_reg == 6'd4) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                tdm_pkg::ALU_DIV: begin
                    a_next   = qbit ? rem_shift - d_reg : rem_shift;
                    b_next   = {b_reg[62:0], 1'b0};
                    acc_next = {64'd0, acc_reg[62:0], qbit};
                    cnt_next = cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                default: busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            pv_reg   <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            pv_reg   <= pv_next;
        end
        op_reg   <= op_next;
        cnt_reg  <= cnt_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        d_reg    <= d_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        sh_reg   <= sh_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign res      = acc_reg;

endmodule

// ===== src/tension_damage_material_step.sv =====
// Top level of the tension damage material step: sequencer, state and ports.
// Depends on tdm_pkg and tdm_alu.
//
//  channel | ports                          | carries
//  s_      | s_tvalid s_tready s_tdata[39:0] | func, strain
//  m_      | m_tvalid m_tready m_tdata[111:0]| stress, tangent, damage
//  cfg_    | cfg_valid cfg_ready cfg_index   | register writes, cfg_data
//
// Tension past the peak runs two 20-term exp series that share the one unit
// (a multiply and a division per term), then up to 43 multiplies for the
// integer part; a zero fracture energy or an exponent of 44 or more skips
// the series.
// Reset is synchronous; s_tready is high only idle, and a result held by a
// stalled m_tready blocks only the end of the following item.
module tension_damage_material_step (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,    // func[1:0], strain[33:2], zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,    // stress[31:0], tangent[79:32], damage[111:80]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    typedef enum logic [16:0] {
        ST_IDLE  = 17'b00000000000000001,
        ST_NEG   = 17'b00000000000000010,
        ST_RATIO = 17'b00000000000000100,
        ST_XMUL  = 17'b00000000000001000,
        ST_XDIV  = 17'b00000000000010000,
        ST_SMUL  = 17'b00000000000100000,
        ST_SDIV  = 17'b00000000001000000,
        ST_POW   = 17'b00000000010000000,
        ST_DMG   = 17'b00000000100000000,
        ST_SMOD  = 17'b00000001000000000,
        ST_SOM   = 17'b00000010000000000,
        ST_TMOD  = 17'b00000100000000000,
        ST_TE1   = 17'b00001000000000000,
        ST_TE2   = 17'b00010000000000000,
        ST_TE3   = 17'b00100000000000000,
        ST_TSEC  = 17'b01000000000000000,
        ST_DONE  = 17'b10000000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   issued_reg, issued_next;

    // configuration
    logic [31:0] modulus_reg, strength_reg, frac_reg;
    logic [30:0] peak_reg;

    // material state
    logic signed [31:0] tr_strain_reg, tr_strain_next;
    logic signed [31:0] tr_stress_reg, tr_stress_next;
    logic signed [47:0] tr_tan_reg, tr_tan_next;
    logic [31:0]        tr_dmg_reg, tr_dmg_next;
    logic signed [31:0] sv_strain_reg, sv_strain_next;
    logic signed [31:0] sv_stress_reg, sv_stress_next;
    logic signed [47:0] sv_tan_reg, sv_tan_next;
    logic [31:0]        sv_dmg_reg, sv_dmg_next;

    // working registers
    logic [30:0] us_reg, us_next;
    logic [30:0] ratio_reg, ratio_next;
    logic [63:0] tmp_reg, tmp_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] e_reg, e_next;
    logic [63:0] e1_reg, e1_next;
    logic [63:0] term_reg, term_next;
    logic [63:0] sum_reg, sum_next;
    logic [4:0]  n_reg, n_next;
    logic        phase_reg, phase_next;
    logic [5:0]  whole_reg, whole_next;
    logic [5:0]  j_reg, j_next;
    logic [31:0] om_reg, om_next;
    logic [63:0] num_hi_reg, num_hi_next;
    logic [63:0] num_lo_reg, num_lo_next;
    logic [32:0] den_reg, den_next;
    logic        neg_reg, neg_next;

    // output register
    logic         m_valid_reg, m_valid_next;
    logic [111:0] m_data_reg, m_data_next;

    // shared unit
    tdm_pkg::alu_req_t alu_req;
    tdm_pkg::alu_rsp_t alu_rsp;
    logic [63:0]       alu_a, alu_b, alu_c;
    logic [127:0]      alu_res;

    logic               s_fire;
    logic [1:0]         in_func;
    logic signed [31:0] in_strain;
    logic [32:0]        in_mag;
    logic               rdone;
    logic [63:0]        sh62;
    logic [63:0]        term_new;
    logic [63:0]        sum_new;
    logic [31:0]        dmg_raw;
    logic [31:0]        dmg_max;
    logic signed [31:0] stress_new;
    logic signed [32:0] ds, de;
    logic [32:0]        ads, ade;

    function automatic logic [47:0] sat_tan(input logic neg, input logic [63:0] mag);
        logic [47:0] r;
        if (neg) begin
            r = (mag >= 64'h8000_0000_0000) ? 48'h8000_0000_0000 : 48'd0 - mag[47:0];
        end else begin
            r = (mag > 64'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : mag[47:0];
        end
        return r;
    endfunction

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign in_func   = s_tdata[1:0];
    assign in_strain = s_tdata[33:2];
    assign in_mag    = 33'd0 - {in_strain[31], in_strain};
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign rdone    = issued_reg && alu_rsp.done;
    assign sh62     = alu_res[125:62];
    assign term_new = alu_res[63:0];
    assign dmg_raw  = tdm_pkg::OneQ31 - sh62[31:0];
    assign dmg_max  = (dmg_raw < sv_dmg_reg) ? sv_dmg_reg : dmg_raw;
    assign stress_new = alu_res[98:67];
    assign ds  = {stress_new[31], stress_new} - {sv_stress_reg[31], sv_stress_reg};
    assign de  = {tr_strain_reg[31], tr_strain_reg} - {sv_strain_reg[31], sv_strain_reg};
    assign ads = ds[32] ? 33'd0 - ds : ds;
    assign ade = de[32] ? 33'd0 - de : de;

    // series partial sum: odd terms subtract (floor at zero), even terms add
    always_comb begin
        if (n_reg[0]) begin
            sum_new = (term_new > sum_reg) ? 64'd0 : sum_reg - term_new;
        end else begin
            sum_new = sum_reg + term_new;
        end
    end

    // operand selection for the shared unit
    always_comb begin
        alu_a = '0;
        alu_b = '0;
        alu_c = '0;
        alu_req.op = tdm_pkg::ALU_MUL;
        unique case (state_reg)
            ST_NEG:   begin alu_a = {32'd0, modulus_reg}; alu_b = tmp_reg; end
            ST_RATIO: begin
                alu_req.op = tdm_pkg::ALU_DIV;
                alu_b = {2'd0, peak_reg, 31'd0};
                alu_c = {33'd0, us_reg};
            end
            ST_XMUL:  begin
                alu_a = {32'd0, strength_reg};
                alu_b = {33'd0, us_reg - peak_reg};
            end
            ST_XDIV:  begin
                alu_req.op = tdm_pkg::ALU_DIV;
                alu_b = tmp_reg;
                alu_c = {28'd0, frac_reg, 4'd0};
            end
            ST_SMUL:  begin alu_a = term_reg; alu_b = phase_reg ? x_reg : tdm_pkg::OneQ62; end
            ST_SDIV:  begin
                alu_req.op = tdm_pkg::ALU_DIV;
                alu_b = tmp_reg;
                alu_c = {59'd0, n_reg};
            end
            ST_POW:   begin alu_a = e_reg; alu_b = e1_reg; end
            ST_DMG:   begin alu_a = e_reg; alu_b = {33'd0, ratio_reg}; end
            ST_SMOD:  begin alu_a = {32'd0, modulus_reg}; alu_b = {33'd0, us_reg}; end
            ST_SOM:   begin alu_a = tmp_reg; alu_b = {32'd0, om_reg}; end
            ST_TMOD:  begin alu_a = {32'd0, modulus_reg}; alu_b = {32'd0, om_reg}; end
            ST_TE1:   begin alu_a = e_reg; alu_b = {32'd0, strength_reg}; end
            ST_TE2:   begin alu_a = tmp_reg; alu_b = {32'd0, strength_reg}; end
            ST_TE3:   begin
                alu_req.op = tdm_pkg::ALU_DIV;
                alu_a = num_hi_reg;
                alu_b = num_lo_reg;
                alu_c = {32'd0, frac_reg};
            end
            ST_TSEC:  begin
                alu_req.op = tdm_pkg::ALU_DIV;
                alu_a = num_hi_reg;
                alu_b = num_lo_reg;
                alu_c = {31'd0, den_reg};
            end
            default:  alu_req.op = tdm_pkg::ALU_MUL;
        endcase
        alu_req.start = !issued_reg && state_reg != ST_IDLE && state_reg != ST_DONE;
    end

    tdm_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .opa     (alu_a),
        .opb     (alu_b),
        .opc     (alu_c),
        .rsp     (alu_rsp),
        .res     (alu_res)
    );

    // sequencer
    always_comb begin
        state_next     = state_reg;
        issued_next    = issued_reg;
        tr_strain_next = tr_strain_reg;
        tr_stress_next = tr_stress_reg;
        tr_tan_next    = tr_tan_reg;
        tr_dmg_next    = tr_dmg_reg;
        sv_strain_next = sv_strain_reg;
        sv_stress_next = sv_stress_reg;
        sv_tan_next    = sv_tan_reg;
        sv_dmg_next    = sv_dmg_reg;
        us_next        = us_reg;
        ratio_next     = ratio_reg;
        tmp_next       = tmp_reg;
        x_next         = x_reg;
        e_next         = e_reg;
        e1_next        = e1_reg;
        term_next      = term_reg;
        sum_next       = sum_reg;
        n_next         = n_reg;
        phase_next     = phase_reg;
        whole_next     = whole_reg;
        j_next         = j_reg;
        om_next        = om_reg;
        num_hi_next    = num_hi_reg;
        num_lo_next    = num_lo_reg;
        den_next       = den_reg;
        neg_next       = neg_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (alu_req.start) begin
            issued_next = 1'b1;
        end
        if (rdone) begin
            issued_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    unique case (in_func)
                        tdm_pkg::FUNC_SET: begin
                            tr_strain_next = in_strain;
                            us_next = in_strain[30:0];
                            if (in_strain[31] || in_strain == 32'sd0) begin
                                tr_tan_next = {16'd0, modulus_reg};
                                tmp_next    = {31'd0, in_mag};
                                state_next  = ST_NEG;
                            end else if (in_strain[30:0] > peak_reg) begin
                                state_next = ST_RATIO;
                            end else begin
                                tr_dmg_next = sv_dmg_reg;
                                om_next     = tdm_pkg::OneQ31 - sv_dmg_reg;
                                state_next  = ST_SMOD;
                            end
                        end
                        tdm_pkg::FUNC_COMMIT: begin
                            sv_strain_next = tr_strain_reg;
                            sv_stress_next = tr_stress_reg;
                            sv_tan_next    = tr_tan_reg;
                            sv_dmg_next    = tr_dmg_reg;
                            state_next     = ST_DONE;
                        end
                        tdm_pkg::FUNC_REVERT: begin
                            tr_strain_next = sv_strain_reg;
                            tr_stress_next = sv_stress_reg;
                            tr_tan_next    = sv_tan_reg;
                            tr_dmg_next    = sv_dmg_reg;
                            state_next     = ST_DONE;
                        end
                        tdm_pkg::FUNC_START: begin
                            tr_strain_next = '0;
                            sv_strain_next = '0;
                            tr_stress_next = '0;
                            sv_stress_next = '0;
                            tr_tan_next    = {16'd0, modulus_reg};
                            sv_tan_next    = {16'd0, modulus_reg};
                            tr_dmg_next    = '0;
                            sv_dmg_next    = '0;
                            state_next     = ST_DONE;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            // compression: stress = -(modulus * |strain|) >> 36
            ST_NEG: begin
                if (rdone) begin
                    tr_stress_next = 32'd0 - alu_res[67:36];
                    state_next     = ST_DONE;
                end
            end
            ST_RATIO: begin
                if (rdone) begin
                    ratio_next = alu_res[30:0];
                    if (frac_reg == 32'd0) begin
                        e_next     = '0;
                        state_next = ST_DMG;
                    end else begin
                        state_next = ST_XMUL;
                    end
                end
            end
            ST_XMUL: begin
                if (rdone) begin
                    tmp_next   = alu_res[63:0];
                    state_next = ST_XDIV;
                end
            end
            // exponent in Q32; start the exp(-1) series first
            ST_XDIV: begin
                if (rdone) begin
                    if (alu_res[63:0] >= tdm_pkg::XLimit) begin
                        e_next     = '0;
                        state_next = ST_DMG;
                    end else begin
                        whole_next = alu_res[37:32];
                        x_next     = {2'd0, alu_res[31:0], 30'd0};
                        phase_next = 1'b0;
                        term_next  = tdm_pkg::OneQ62;
                        sum_next   = tdm_pkg::OneQ62;
                        n_next     = 5'd1;
                        state_next = ST_SMUL;
                    end
                end
            end
            ST_SMUL: begin
                if (rdone) begin
                    tmp_next   = sh62;
                    state_next = ST_SDIV;
                end
            end
            ST_SDIV: begin
                if (rdone) begin
                    term_next = term_new;
                    sum_next  = sum_new;
                    n_next    = n_reg + 5'd1;
                    state_next = ST_SMUL;
                    if (n_reg == 5'(tdm_pkg::ExpTerms)) begin
                        if (!phase_reg) begin
                            e1_next    = sum_new;
                            phase_next = 1'b1;
                            term_next  = tdm_pkg::OneQ62;
                            sum_next   = tdm_pkg::OneQ62;
                            n_next     = 5'd1;
                        end else begin
                            e_next = sum_new;
                            j_next = '0;
                            state_next = (whole_reg == 6'd0) ? ST_DMG : ST_POW;
                        end
                    end
                end
            end
            // integer part: one exp(-1) factor per unit
            ST_POW: begin
                if (rdone) begin
                    e_next = sh62;
                    j_next = j_reg + 6'd1;
                    if (j_reg + 6'd1 == whole_reg) begin
                        state_next = ST_DMG;
                    end
                end
            end
            ST_DMG: begin
                if (rdone) begin
                    tr_dmg_next = dmg_max;
                    om_next     = tdm_pkg::OneQ31 - dmg_max;
                    state_next  = ST_SMOD;
                end
            end
            ST_SMOD: begin
                if (rdone) begin
                    tmp_next   = alu_res[63:0];
                    state_next = ST_SOM;
                end
            end
            // stress, then pick the tangent form
            ST_SOM: begin
                if (rdone) begin
                    tr_stress_next = stress_new;
                    if (tr_dmg_reg == sv_dmg_reg) begin
                        state_next = ST_TMOD;
                    end else if (sv_dmg_reg != 32'd0) begin
                        if (frac_reg != 32'd0) begin
                            state_next = ST_TE1;
                        end else begin
                            tr_tan_next = '0;
                            state_next  = ST_DONE;
                        end
                    end else if (de == 33'sd0) begin
                        state_next = ST_TMOD;
                    end else begin
                        num_hi_next = {59'd0, ads[32:28]};
                        num_lo_next = {ads[27:0], 36'd0};
                        den_next    = ade;
                        neg_next    = ds[32] != de[32];
                        state_next  = ST_TSEC;
                    end
                end
            end
            ST_TMOD: begin
                if (rdone) begin
                    tr_tan_next = {16'd0, alu_res[62:31]};
                    state_next  = ST_DONE;
                end
            end
            ST_TE1: begin
                if (rdone) begin
                    tmp_next   = alu_res[93:30];
                    state_next = ST_TE2;
                end
            end
            ST_TE2: begin
                if (rdone) begin
                    num_hi_next = {32'd0, alu_res[127:96]};
                    num_lo_next = alu_res[95:32];
                    state_next  = ST_TE3;
                end
            end
            ST_TE3: begin
                if (rdone) begin
                    tr_tan_next = sat_tan(1'b1, alu_res[63:0]);
                    state_next  = ST_DONE;
                end
            end
            ST_TSEC: begin
                if (rdone) begin
                    tr_tan_next = sat_tan(neg_reg, alu_res[63:0]);
                    state_next  = ST_DONE;
                end
            end
            // hand the trial values to the output register
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {tr_dmg_reg, tr_tan_reg, tr_stress_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control and material state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
            modulus_reg   <= tdm_pkg::ModReset;
            strength_reg  <= tdm_pkg::StrengthReset;
            frac_reg      <= tdm_pkg::FracReset;
            peak_reg      <= tdm_pkg::PeakReset;
            tr_strain_reg <= '0;
            tr_stress_reg <= '0;
            tr_tan_reg    <= {16'd0, tdm_pkg::ModReset};
            tr_dmg_reg    <= '0;
            sv_strain_reg <= '0;
            sv_stress_reg <= '0;
            sv_tan_reg    <= {16'd0, tdm_pkg::ModReset};
            sv_dmg_reg    <= '0;
        end else begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            m_valid_reg   <= m_valid_next;
            tr_strain_reg <= tr_strain_next;
            tr_stress_reg <= tr_stress_next;
            tr_tan_reg    <= tr_tan_next;
            tr_dmg_reg    <= tr_dmg_next;
            sv_strain_reg <= sv_strain_next;
            sv_stress_reg <= sv_stress_next;
            sv_tan_reg    <= sv_tan_next;
            sv_dmg_reg    <= sv_dmg_next;
            if (cfg_valid && cfg_ready) begin
                priority case (cfg_index)
                    tdm_pkg::CFG_MODULUS:  modulus_reg  <= cfg_data;
                    tdm_pkg::CFG_STRENGTH: strength_reg <= cfg_data;
                    tdm_pkg::CFG_FRACTURE: frac_reg     <= cfg_data;
                    tdm_pkg::CFG_PEAK:     peak_reg     <= cfg_data[30:0];
                    default:               peak_reg     <= peak_reg;
                endcase
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        us_reg     <= us_next;
        ratio_reg  <= ratio_next;
        tmp_reg    <= tmp_next;
        x_reg      <= x_next;
        e_reg      <= e_next;
        e1_reg     <= e1_next;
        term_reg   <= term_next;
        sum_reg    <= sum_next;
        n_reg      <= n_next;
        phase_reg  <= phase_next;
        whole_reg  <= whole_next;
        j_reg      <= j_next;
        om_reg     <= om_next;
        num_hi_reg <= num_hi_next;
        num_lo_reg <= num_lo_next;
        den_reg    <= den_next;
        neg_reg    <= neg_next;
        m_data_reg <= m_data_next;
    end

    // damage never exceeds one
    a_dmg_range: assert property (@(posedge aclk) disable iff (!aresetn)
        tr_dmg_reg <= tdm_pkg::OneQ31)
        else $error("trial damage above one");

    // the unit is never started while it is still working
    a_alu_free: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_req.start |-> !alu_rsp.busy)
        else $error("shared unit restarted while busy");

    // a unit result only arrives for an issued request
    a_alu_done: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_rsp.done |-> issued_reg)
        else $error("unexpected unit result");

    // an accepted item always leaves the idle state
    a_leave_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> state_reg != ST_IDLE)
        else $error("accepted item dropped");

endmodule
